>>> design/dpc_pkg.sv
// Package for the dihedral pattern census: shared types, constants and
// the dihedral transform helpers. No dependencies.
`timescale 1ns / 1ps
package dpc_pkg;
   localparam int PAT_BITS = 25;
   localparam int RAD_BITS = 2;

   typedef enum logic [1:0] {
      ST_COUNTED = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [PAT_BITS-1:0] pattern;
      logic                centre;
      logic                empty;
   } job_type;

   // Input word: one window bitmap and its centre flag.
   typedef struct packed {
      logic [PAT_BITS-1:0] window_bits;
      logic                centre_occupied;
   } window_type;

   // Result word: canonical pattern and its table entry.
   typedef struct packed {
      logic [PAT_BITS-1:0] canonical_pattern;
      logic                which_table;
      logic [7:0]          entry_index;
      logic [15:0]         occurrence_count;
      logic                is_new;
      status_type          status;
   } census_type;

   // Quarter turn of an s-by-s window: new(y,x) = old(x, s-1-y).
   function automatic logic [PAT_BITS-1:0] turn_f(input logic [PAT_BITS-1:0] v,
                                                  input int s);
      logic [PAT_BITS-1:0] r;
      r = '0;
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            if (y < s && x < s) begin
               r[y*s+x] = v[x*s+(s-1-y)];
            end
         end
      end
      return r;
   endfunction

   // Left-right mirror: new(y,x) = old(y, s-1-x).
   function automatic logic [PAT_BITS-1:0] mirror_f(input logic [PAT_BITS-1:0] v,
                                                    input int s);
      logic [PAT_BITS-1:0] r;
      r = '0;
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            if (y < s && x < s) begin
               r[y*s+x] = v[y*s+(s-1-x)];
            end
         end
      end
      return r;
   endfunction
endpackage

>>> design/dpc_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface dpc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> design/dpc_ram.sv
// Generic RAM with one write port and one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module dpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/dpc_front.sv
// Front end: masks the window, finds the canonical form with three quarter
// turns (one a cycle) and pushes a job into a two-entry queue.
// Depends on dpc_pkg.
`timescale 1ns / 1ps
module dpc_front #(
   parameter int MAX_SIDE = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dpc_pkg::RAD_BITS-1:0]  radius,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [dpc_pkg::PAT_BITS-1:0]  in_bits,
   input  logic                          in_centre,
   output logic                          job_valid,
   input  logic                          job_ready,
   output dpc_pkg::job_type              job
);
   import dpc_pkg::*;

   localparam int MAX_RAD = (MAX_SIDE - 1) / 2;

   logic                busy_ff, busy_in;
   logic [1:0]          step_ff, step_in;
   logic [PAT_BITS-1:0] a_ff, a_in, b_ff, b_in, best_ff, best_in;
   logic                centre_ff, centre_in;
   logic [2:0]          side_ff, side_in;
   job_type             q_ff [2];
   logic [1:0]          q_in_dummy;
   logic                wp_ff, rp_ff;
   logic [1:0]          cnt_ff;
   logic                push, pop;
   logic [PAT_BITS-1:0] win, mir, ta, tb, lo;
   logic [2:0]          side;
   int                  nb;

   always_comb begin
      side = (32'(radius) > MAX_RAD) ? 3'(2*MAX_RAD+1) : 3'({radius, 1'b1});
      nb   = int'(side) * int'(side);
      win  = '0;
      for (int i = 0; i < PAT_BITS; i++) begin
         if (i < nb) begin
            win[i] = in_bits[i];
         end
      end
      mir = mirror_f(win, int'(side));
   end

   assign ta = turn_f(a_ff, int'(side_ff));
   assign tb = turn_f(b_ff, int'(side_ff));
   assign lo = (ta < tb) ? ta : tb;

   assign in_ready   = !busy_ff;
   assign push       = busy_ff && step_ff == 2'd3 && cnt_ff != 2'd2;
   assign pop        = job_valid && job_ready;
   assign job_valid  = cnt_ff != 2'd0;
   assign job        = q_ff[rp_ff];
   assign q_in_dummy = cnt_ff;

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      best_in   = best_ff;
      centre_in = centre_ff;
      side_in   = side_ff;
      if (!busy_ff) begin
         if (in_valid) begin
            busy_in   = 1'b1;
            step_in   = 2'd0;
            a_in      = win;
            b_in      = mir;
            best_in   = (mir < win) ? mir : win;
            centre_in = in_centre;
            side_in   = side;
         end
      end else if (step_ff != 2'd3) begin
         // advance one quarter turn on both chains
         a_in    = ta;
         b_in    = tb;
         best_in = (lo < best_ff) ? lo : best_ff;
         step_in = step_ff + 2'd1;
      end else if (push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      best_ff   <= best_in;
      centre_ff <= centre_in;
      side_ff   <= side_in;
      step_ff   <= step_in;
      if (push) begin
         q_ff[wp_ff] <= '{pattern: best_ff, centre: centre_ff,
                          empty: (!centre_ff && best_ff == '0)};
      end
      if (reset) begin
         busy_ff <= 1'b0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= q_in_dummy + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> design/dpc_back.sv
// Back end: searches the selected table slot by slot (read, then compare),
// then counts, inserts, reports full or reports an empty window, and holds
// the result word. Depends on dpc_pkg and dpc_ram.
`timescale 1ns / 1ps
module dpc_back #(
   parameter int TABLE_DEPTH = 256,
   parameter int COUNT_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_ready,
   input  dpc_pkg::job_type               job,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [dpc_pkg::PAT_BITS-1:0]   out_pattern,
   output logic                           out_table,
   output logic [7:0]                     out_index,
   output logic [15:0]                    out_count,
   output logic                           out_new,
   output dpc_pkg::status_type            out_status
);
   import dpc_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int UW = AW + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_CMP   = 5'b00100,
      S_CREAD = 5'b01000,
      S_CWR   = 5'b10000
   } state_type;

   state_type           st_ff;
   job_type             job_ff;
   logic [UW-1:0]       used_ff [2];
   logic [UW-1:0]       idx_ff;
   logic                ov_ff;
   logic                tsel;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                pw_en [2], cw_en [2];
   logic [PAT_BITS-1:0] pat_q [2];
   logic [COUNT_BITS-1:0] cnt_q [2], cnt_w, cnt_inc;
   logic [UW-1:0]       used;

   assign tsel      = job_ff.centre;
   assign used      = used_ff[tsel];
   assign rd_addr   = idx_ff[AW-1:0];
   assign wr_addr   = idx_ff[AW-1:0];
   assign job_ready = (st_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign cnt_inc   = (cnt_q[tsel] < CMAX) ? cnt_q[tsel] + 1'b1 : cnt_q[tsel];
   assign cnt_w     = (st_ff == S_CWR) ? cnt_inc : COUNT_BITS'(1);

   for (genvar t = 0; t < 2; t++) begin : g_tab
      dpc_ram #(.WIDTH(PAT_BITS), .DEPTH(TABLE_DEPTH)) u_pat (
         .clock(clock), .wr_en(pw_en[t]), .wr_addr(wr_addr),
         .wr_data(job_ff.pattern), .rd_addr(rd_addr), .rd_data(pat_q[t]));
      dpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_cnt (
         .clock(clock), .wr_en(cw_en[t]), .wr_addr(wr_addr),
         .wr_data(cnt_w), .rd_addr(rd_addr), .rd_data(cnt_q[t]));
   end

   logic miss_end, hit;
   assign miss_end = (st_ff == S_READ) && (idx_ff >= used);
   assign hit      = (st_ff == S_CMP) && (pat_q[tsel] == job_ff.pattern);

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         pw_en[t] = miss_end && (int'(used) < TABLE_DEPTH) && (tsel == t[0]);
         cw_en[t] = ((st_ff == S_CWR) || pw_en[t]) && (tsel == t[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         ov_ff      <= 1'b0;
         used_ff[0] <= '0;
         used_ff[1] <= '0;
      end else begin
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (job_valid && !ov_ff) begin
                  job_ff      <= job;
                  idx_ff      <= '0;
                  out_pattern <= job.pattern;
                  out_table   <= !job.centre;
                  out_index   <= '0;
                  out_count   <= '0;
                  out_new     <= 1'b0;
                  if (job.empty) begin
                     out_status <= ST_EMPTY;
                     ov_ff      <= 1'b1;
                  end else begin
                     st_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               if (miss_end) begin
                  // insert at the fill point or report full
                  if (int'(used) < TABLE_DEPTH) begin
                     used_ff[tsel] <= used + 1'b1;
                     out_index     <= 8'(idx_ff);
                     out_count     <= 16'(COUNT_BITS'(1));
                     out_new       <= 1'b1;
                     out_status    <= ST_COUNTED;
                  end else begin
                     out_status <= ST_FULL;
                  end
                  ov_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  st_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (hit) begin
                  st_ff <= S_CREAD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff  <= S_READ;
               end
            end
            S_CREAD: st_ff <= S_CWR;
            S_CWR: begin
               out_index  <= 8'(idx_ff);
               out_count  <= 16'(cnt_inc);
               out_status <= ST_COUNTED;
               ov_ff      <= 1'b1;
               st_ff      <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> design/dihedral_pattern_census.sv
// Dihedral pattern census top level.
// Path to a result: an empty window is reported without a search; an insert or
// table full follows a scan of the filled slots; a hit scans to its slot, then reads and writes the count.
// Flow: the front takes a new word only after its last job is queued; the scan sets the rate.
// Reset: synchronous, clears fill counts and handshakes; radius returns to 2.
// Table contents are not cleared; only slots below the fill count are read.
`timescale 1ns / 1ps
module dihedral_pattern_census #(
   parameter int TABLE_DEPTH = 256,
   parameter int COUNT_BITS  = 16,
   parameter int MAX_SIDE    = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   dpc_if.sink        req,
   dpc_if.source      rsp
);
   import dpc_pkg::*;

   logic [RAD_BITS-1:0] radius_ff;
   logic    job_valid, job_ready;
   job_type job;

   // hold the radius register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 2'd2;
      end else if (csr_write_enable) begin
         radius_ff <= csr_write_data;
      end
   end

   dpc_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock(clock), .reset(reset), .radius(radius_ff),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_bits(req.data.window_bits), .in_centre(req.data.centre_occupied),
      .job_valid(job_valid), .job_ready(job_ready), .job(job));

   dpc_back #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_pattern(rsp.data.canonical_pattern), .out_table(rsp.data.which_table),
      .out_index(rsp.data.entry_index), .out_count(rsp.data.occurrence_count),
      .out_new(rsp.data.is_new), .out_status(rsp.data.status));
endmodule
